// ===== rtl/bds_pkg.sv =====
package bds_pkg;

  localparam int LANES   = 4;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 9;
  localparam int PX_W    = LANES * CH_W;
  localparam int PAIR_W  = LANES * SUM_W;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [12:0] SRC_WIDTH_RST     = 13'd1;
  localparam logic [15:0] SRC_HEIGHT_RST    = 16'd1;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd4;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // back-end operation codes
  localparam logic [1:0] OP_STORE = 2'd0;  // even row: park pair sums in line store
  localparam logic [1:0] OP_LOAD  = 2'd1;  // odd row: add to stored pair sums, emit
  localparam logic [1:0] OP_SELF  = 2'd2;  // height one: pair sums count twice, emit

  typedef struct packed {
    logic [12:0] src_width;
    logic [15:0] src_height;
    logic [2:0]  channel_count;
  } bds_cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              last;
    logic [LANES-1:0]  mask;
    logic [PAIR_W-1:0] pair;
  } bds_cmd_t;

  typedef struct packed {
    logic [PX_W-1:0] data;
    logic            last;
  } bds_out_t;

endpackage

// ===== rtl/box_downscale_2x2_unit.sv =====
// 2x2 box-filter downscaler, one mipmap step.
// Input channel: source pixels in raster order, four 8-bit channels each
// (in_chan0..3). A pixel is taken when push is high and full is low.
// Result channel: one half-size pixel per 2x2 block (out_out0..3, with
// out_frame_last marking the final pixel of the image). The oldest result
// shows while empty is low and is taken when pop is high.
// Configuration: APB-style writes to src_width (0x0), src_height (0x4)
// and channel_count (0x8); any such write restarts the frame. Write only
// while the block is idle. pready is tied high; reads return the register.
// Throughput: one source pixel per clock while full is low. Rate is set by the
// single-port line store, touched once per pixel pair.
// A result passes from the edge that accepted the pixel completing its block
// through the command queue and the line-store read register into the result queue.
// Reset (rst_n low, synchronous) empties both queues, zeroes the column
// and row counters and loads width 1, height 1, four channels.
// A stalled receiver fills the four-entry result queue; the back end then
// stops draining the command queue and full rises once that fills.
module box_downscale_2x2_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // source pixels
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_chan0,
  input  logic [7:0]                   in_chan1,
  input  logic [7:0]                   in_chan2,
  input  logic [7:0]                   in_chan3,
  // downscaled pixels
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_out0,
  output logic [7:0]                   out_out1,
  output logic [7:0]                   out_out2,
  output logic [7:0]                   out_out3,
  output logic                         out_frame_last,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bds_pkg::ADDR_W-1:0]   paddr,
  input  logic [bds_pkg::DATA_W-1:0]   pwdata,
  output logic [bds_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bds_pkg::*;

  localparam int IDX_W = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [12:0] src_width_r, src_width_nxt;
  logic [15:0] src_height_r, src_height_nxt;
  logic [2:0]  channel_count_r, channel_count_nxt;
  logic [1:0]  reg_sel;
  logic        wr_req, restart;
  bds_cfg_t    cfg;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_req  = psel & penable & pwrite & pready;

  always_comb begin
    src_width_nxt     = src_width_r;
    src_height_nxt    = src_height_r;
    channel_count_nxt = channel_count_r;
    restart           = 1'b0;
    if (wr_req) begin
      case (reg_sel)
        REG_SRC_WIDTH: begin
          src_width_nxt = pwdata[12:0];
          restart       = 1'b1;
        end
        REG_SRC_HEIGHT: begin
          src_height_nxt = pwdata[15:0];
          restart        = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          channel_count_nxt = pwdata[2:0];
          restart           = 1'b1;
        end
        default: begin
          restart = 1'b0;  // unmapped: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r     <= SRC_WIDTH_RST;
      src_height_r    <= SRC_HEIGHT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
    end else begin
      src_width_r     <= src_width_nxt;
      src_height_r    <= src_height_nxt;
      channel_count_r <= channel_count_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_WIDTH:     prdata = {19'd0, src_width_r};
      REG_SRC_HEIGHT:    prdata = {16'd0, src_height_r};
      REG_CHANNEL_COUNT: prdata = {29'd0, channel_count_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.src_width     = src_width_r;
  assign cfg.src_height    = src_height_r;
  assign cfg.channel_count = channel_count_r;

  // ---------------------------------------------------------------------
  // Front: counters, held pixel, pair sums, command build
  // ---------------------------------------------------------------------
  logic             accept, f_valid, q_full, q_valid, q_pop;
  bds_cmd_t         f_cmd, q_cmd;
  logic [IDX_W-1:0] f_idx, q_idx;

  assign accept = push & ~q_full;
  assign full   = q_full;

  bds_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .restart   (restart),
    .accept    (accept),
    .px        ({in_chan3, in_chan2, in_chan1, in_chan0}),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_idx   (f_idx)
  );

  // Command queue: only pixels completing a pair enter it.
  bds_cmdq #(.IDX_W(IDX_W)) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_valid),
    .wr_cmd   (f_cmd),
    .wr_idx   (f_idx),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_idx   (q_idx)
  );

  // ---------------------------------------------------------------------
  // Back: line store, vertical sum, result queue
  // ---------------------------------------------------------------------
  bds_out_t res;

  bds_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_idx     (q_idx),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_out0       = res.data[7:0];
  assign out_out1       = res.data[15:8];
  assign out_out2       = res.data[23:16];
  assign out_out3       = res.data[31:24];
  assign out_frame_last = res.last;

endmodule

// ===== rtl/bds_front.sv =====
module bds_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bds_pkg::bds_cfg_t             cfg,
  input  logic                          restart,
  input  logic                          accept,
  input  logic [bds_pkg::PX_W-1:0]      px,
  output logic                          cmd_valid,
  output bds_pkg::bds_cmd_t             cmd,
  output logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] cmd_idx
);
  import bds_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int IDX_W      = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int EW         = (WW > 13) ? WW : 13;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [15:0]       row_r, row_nxt;
  logic [PX_W-1:0]   held_r, held_nxt;

  logic [EW-1:0]     eff_w, dst_w, half, idx;
  logic [15:0]       eff_h, dst_h;
  logic [2:0]        nch;
  logic              w_one, h_one, ready, last_col, last_row;

  always_comb begin
    logic [EW-1:0] wide_w;
    wide_w = EW'(cfg.src_width);
    if (cfg.src_width == 13'd0) begin
      eff_w = EW'(1);
    end else if (wide_w > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = wide_w;
    end
    eff_h = (cfg.src_height == 16'd0) ? 16'd1 : cfg.src_height;
    if (cfg.channel_count == 3'd0) begin
      nch = 3'd1;
    end else if (cfg.channel_count > 3'd4) begin
      nch = 3'd4;
    end else begin
      nch = cfg.channel_count;
    end
  end

  assign w_one    = (eff_w == EW'(1));
  assign h_one    = (eff_h == 16'd1);
  assign ready    = w_one | col_r[0];
  assign last_col = (EW'(col_r) >= eff_w - EW'(1));
  assign last_row = (row_r >= eff_h - 16'd1);
  assign half     = EW'(col_r) >> 1;
  assign idx      = (half > EW'(LINE_DEPTH - 1)) ? EW'(LINE_DEPTH - 1) : half;
  assign dst_w    = w_one ? EW'(1) : (eff_w >> 1);
  assign dst_h    = h_one ? 16'd1 : (eff_h >> 1);

  // horizontal pair sums and command build
  always_comb begin
    logic [CH_W-1:0] a, b;
    cmd.pair = '0;
    for (int k = 0; k < LANES; k++) begin
      a = px[k*CH_W +: CH_W];
      b = w_one ? a : held_r[k*CH_W +: CH_W];
      cmd.pair[k*SUM_W +: SUM_W] = {1'b0, a} + {1'b0, b};
      cmd.mask[k] = (3'(k) < nch);
    end
    if (h_one) begin
      cmd.op = OP_SELF;
    end else if (!row_r[0]) begin
      cmd.op = OP_STORE;
    end else begin
      cmd.op = OP_LOAD;
    end
    cmd.last = (idx == dst_w - EW'(1)) && ((row_r >> 1) == dst_h - 16'd1);
  end

  assign cmd_idx   = idx[IDX_W-1:0];
  assign cmd_valid = accept & ready;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      held_nxt = '0;
    end else if (accept) begin
      if (!ready) begin
        held_nxt = px;
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/bds_cmdq.sv =====
module bds_cmdq #(
  parameter int IDX_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bds_pkg::bds_cmd_t wr_cmd,
  input  logic [IDX_W-1:0]  wr_idx,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output bds_pkg::bds_cmd_t rd_cmd,
  output logic [IDX_W-1:0]  rd_idx
);
  import bds_pkg::*;

  bds_cmd_t               cmd_q [CMDQ_DEPTH];
  logic [IDX_W-1:0]       idx_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMDQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   do_wr, do_rd;

  assign full     = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & rd_valid;
  assign rd_cmd   = cmd_q[rp_r];
  assign rd_idx   = idx_q[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + CMDQ_PTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + CMDQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CMDQ_CNT_W'(do_wr) - CMDQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      cmd_q[wp_r] <= wr_cmd;
      idx_q[wp_r] <= wr_idx;
    end
  end

endmodule

// ===== rtl/bds_back.sv =====
module bds_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bds_pkg::bds_cmd_t             q_cmd,
  input  logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] q_idx,
  output logic                          q_pop,
  input  logic                          res_pop,
  output logic                          res_empty,
  output bds_pkg::bds_out_t             res
);
  import bds_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;

  // line store of even-row pair sums
  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] rd_r;

  logic              b_valid_r, b_valid_nxt;
  bds_cmd_t          b_cmd_r;

  bds_out_t              oq [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owp_r, owp_nxt, orp_r, orp_nxt;
  logic [OUTQ_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [OUTQ_CNT_W:0]   load;
  logic                  emit, do_opop;
  bds_out_t              emit_data;

  // slots taken by queued results plus the command held in the back stage
  assign load  = {1'b0, ocnt_r} + (OUTQ_CNT_W+1)'(b_valid_r);
  assign q_pop = q_valid && (load < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_cmd.op == OP_STORE) begin
        line_mem[q_idx] <= q_cmd.pair;
      end
      rd_r    <= line_mem[q_idx];
      b_cmd_r <= q_cmd;
    end
  end

  assign b_valid_nxt = q_pop;

  always_comb begin
    logic [PAIR_W-1:0] other;
    logic [SUM_W:0]    s;
    other = (b_cmd_r.op == OP_LOAD) ? rd_r : b_cmd_r.pair;
    emit_data.data = '0;
    for (int k = 0; k < LANES; k++) begin
      s = {1'b0, b_cmd_r.pair[k*SUM_W +: SUM_W]} + {1'b0, other[k*SUM_W +: SUM_W]};
      emit_data.data[k*CH_W +: CH_W] = b_cmd_r.mask[k] ? s[SUM_W:2] : '0;
    end
    emit_data.last = b_cmd_r.last;
  end

  assign emit    = b_valid_r && (b_cmd_r.op != OP_STORE);
  assign do_opop = res_pop && !res_empty;

  always_comb begin
    owp_nxt  = emit ? owp_r + OUTQ_PTR_W'(1) : owp_r;
    orp_nxt  = do_opop ? orp_r + OUTQ_PTR_W'(1) : orp_r;
    ocnt_nxt = ocnt_r + OUTQ_CNT_W'(emit) - OUTQ_CNT_W'(do_opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      owp_r     <= '0;
      orp_r     <= '0;
      ocnt_r    <= '0;
    end else begin
      b_valid_r <= b_valid_nxt;
      owp_r     <= owp_nxt;
      orp_r     <= orp_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[owp_r] <= emit_data;
    end
  end

  assign res_empty = (ocnt_r == '0);
  assign res       = oq[orp_r];

endmodule

// ===== rtl/bds_checker.sv =====
module bds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [7:0]                 out_out0,
  input logic [7:0]                 out_out1,
  input logic [7:0]                 out_out2,
  input logic [7:0]                 out_out3,
  input logic                       out_frame_last,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [bds_pkg::ADDR_W-1:0] paddr,
  input logic [bds_pkg::DATA_W-1:0] pwdata,
  input logic [bds_pkg::DATA_W-1:0] prdata
);
  import bds_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_out0) && $stable(out_out1) &&
                          $stable(out_out2) && $stable(out_out3) &&
                          $stable(out_frame_last)))
    else $error("waiting result changed or vanished");

  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[3:2] == REG_SRC_WIDTH) |=>
      (paddr[3:2] != REG_SRC_WIDTH || prdata[12:0] == $past(pwdata[12:0])))
    else $error("src_width readback mismatch");

endmodule

bind box_downscale_2x2_unit bds_checker u_bds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_out0       (out_out0),
  .out_out1       (out_out1),
  .out_out2       (out_out2),
  .out_out3       (out_out3),
  .out_frame_last (out_frame_last),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
